FILE: sv/assert_macros.svh
// assertion macros included by the parser rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// consequence required in the cycle after the antecedent
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: sv/matp_pkg.sv
// types, constants and character helpers of the mac address text parser
`timescale 1ns / 1ps

package matp_pkg;

  localparam int unsigned PosW = 5;
  localparam int unsigned AddrW = 48;

  localparam logic [PosW-1:0] TextLen = 5'd17;
  localparam logic [PosW-1:0] PosSat = 5'd18;

  localparam logic [7:0] ChDash = 8'h2d;
  localparam logic [7:0] ChDot = 8'h2e;
  localparam logic [7:0] ChColon = 8'h3a;

  localparam logic [AddrW-1:0] AddrOnes = {AddrW{1'b1}};
  localparam logic [AddrW-1:0] McastBit = 48'h0100_0000_0000;

  typedef enum logic [2:0] {
    CAUSE_OK    = 3'd0,
    CAUSE_LEN   = 3'd1,
    CAUSE_SEP   = 3'd2,
    CAUSE_DIGIT = 3'd3,
    CAUSE_RSVD  = 3'd4
  } cause_e;

  function automatic logic is_sep(input logic [7:0] c);
    return (c == ChDash) || (c == ChDot) || (c == ChColon);
  endfunction

  function automatic logic is_sep_pos(input logic [PosW-1:0] p);
    return (p == 5'd2) || (p == 5'd5) || (p == 5'd8) || (p == 5'd11) || (p == 5'd14);
  endfunction

  function automatic logic is_hex(input logic [7:0] c);
    return ((c >= 8'h30) && (c <= 8'h39)) || ((c >= 8'h61) && (c <= 8'h66)) ||
           ((c >= 8'h41) && (c <= 8'h46));
  endfunction

  // nibble value of a hex digit, zero for any other code
  function automatic logic [3:0] hex_nibble(input logic [7:0] c);
    logic [7:0] v;
    v = 8'h00;
    if ((c >= 8'h30) && (c <= 8'h39)) begin
      v = c - 8'h30;
    end else if ((c >= 8'h61) && (c <= 8'h66)) begin
      v = c - 8'h57;
    end else if ((c >= 8'h41) && (c <= 8'h46)) begin
      v = c - 8'h37;
    end
    return v[3:0];
  endfunction

endpackage

FILE: sv/matp_if.sv
// stream interfaces for characters in and verdicts out
`timescale 1ns / 1ps

interface matp_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       is_last;

  modport source (output valid, output char_code, output is_last, input ready);
  modport sink (input valid, input char_code, input is_last, output ready);
endinterface

interface matp_verdict_if import matp_pkg::*; ;
  logic             valid;
  logic             ready;
  logic             accepted;
  cause_e           cause;
  logic [AddrW-1:0] address;

  modport source (output valid, output accepted, output cause, output address, input ready);
  modport sink (input valid, input accepted, input cause, input address, output ready);
endinterface

FILE: sv/mac_address_text_parser_unit.sv
// mac address text parser: one character per transfer, one verdict per text
//
// channel   direction  payload
// chr_i     in         char_code[7:0], is_last
// vrd_o     out        accepted, cause[2:0], address[47:0]
//
// one character is taken every cycle unless a held verdict stalls chr_i; the verdict
// register loads in the same edge that takes the last character and shows it from
// the next cycle on; a held verdict stalls chr_i only while vrd_o.ready is low
// rst_ni clears position, accumulator, error flags and the verdict valid
`timescale 1ns / 1ps

module mac_address_text_parser_unit import matp_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  matp_char_if.sink         chr_i,
  matp_verdict_if.source    vrd_o
);

  `include "assert_macros.svh"

  logic [PosW-1:0]  pos_q, pos_d, count;
  logic [AddrW-1:0] acc_q, acc_d, acc_shift;
  logic             sep_err_q, sep_err_d;
  logic             dig_err_q, dig_err_d;
  logic             vld_q;
  logic             acc_ok_q, acc_ok_d;
  cause_e           cause_q, cause_d;
  logic [AddrW-1:0] addr_q, addr_d;
  logic             in_xfer;
  logic             in_range;
  logic             sep_slot;

  assign chr_i.ready = !vld_q || vrd_o.ready;
  assign in_xfer     = chr_i.valid && chr_i.ready;

  assign in_range  = pos_q < TextLen;
  assign sep_slot  = is_sep_pos(pos_q);
  assign acc_shift = {acc_q[AddrW-5:0], hex_nibble(chr_i.char_code)};
  assign count     = (pos_q == PosSat) ? PosSat : pos_q + 5'd1;

  // text state after this character
  logic [AddrW-1:0] acc_n;
  logic             sep_err_n, dig_err_n;

  always_comb begin
    acc_n     = acc_q;
    sep_err_n = sep_err_q;
    dig_err_n = dig_err_q;
    if (in_range) begin
      if (sep_slot) begin
        sep_err_n = sep_err_q || !is_sep(chr_i.char_code);
      end else begin
        acc_n     = acc_shift;
        dig_err_n = dig_err_q || !is_hex(chr_i.char_code);
      end
    end
  end

  always_comb begin
    priority if (count != TextLen) begin
      cause_d = CAUSE_LEN;
    end else if (sep_err_n) begin
      cause_d = CAUSE_SEP;
    end else if (dig_err_n) begin
      cause_d = CAUSE_DIGIT;
    end else if ((acc_n == '0) || (acc_n == AddrOnes) || ((acc_n & McastBit) != '0)) begin
      cause_d = CAUSE_RSVD;
    end else begin
      cause_d = CAUSE_OK;
    end
    acc_ok_d = (cause_d == CAUSE_OK);
    addr_d   = acc_ok_d ? acc_n : '0;
  end

  always_comb begin
    pos_d     = pos_q;
    acc_d     = acc_q;
    sep_err_d = sep_err_q;
    dig_err_d = dig_err_q;
    if (in_xfer) begin
      if (chr_i.is_last) begin
        pos_d     = '0;
        acc_d     = '0;
        sep_err_d = 1'b0;
        dig_err_d = 1'b0;
      end else begin
        pos_d     = count;
        acc_d     = acc_n;
        sep_err_d = sep_err_n;
        dig_err_d = dig_err_n;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= '0;
      acc_q     <= '0;
      sep_err_q <= 1'b0;
      dig_err_q <= 1'b0;
      vld_q     <= 1'b0;
    end else begin
      pos_q     <= pos_d;
      acc_q     <= acc_d;
      sep_err_q <= sep_err_d;
      dig_err_q <= dig_err_d;
      if (in_xfer && chr_i.is_last) begin
        vld_q <= 1'b1;
      end else if (vrd_o.ready) begin
        vld_q <= 1'b0;
      end
    end
  end

  // verdict payload
  always_ff @(posedge clk_i) begin
    if (in_xfer && chr_i.is_last) begin
      acc_ok_q <= acc_ok_d;
      cause_q  <= cause_d;
      addr_q   <= addr_d;
    end
  end

  assign vrd_o.valid    = vld_q;
  assign vrd_o.accepted = acc_ok_q;
  assign vrd_o.cause    = cause_q;
  assign vrd_o.address  = addr_q;

  `ASSERT_ALWAYS(a_pos_sat, clk_i, rst_ni, pos_q <= PosSat, "position beyond saturation")
  `ASSERT_ALWAYS(a_ok_match, clk_i, rst_ni, !vld_q || (acc_ok_q == (cause_q == CAUSE_OK)), "accepted and cause disagree")
  `ASSERT_ALWAYS(a_addr_zero, clk_i, rst_ni, !vld_q || acc_ok_q || (addr_q == '0), "address not cleared on refusal")
  `ASSERT_NEXT(a_last_verdict, clk_i, rst_ni, in_xfer && chr_i.is_last, vld_q && (pos_q == '0), "last character gave no verdict")

endmodule

FILE: tb/tb_top.sv
// testbench of the mac address text parser: directed and random texts checked against a predictor
`timescale 1ns / 1ps

module tb_top;
  import matp_pkg::*;

  localparam int unsigned GapMax = 4;
  localparam int unsigned IdleLimit = 2000;
  localparam int unsigned SettleCycles = 8;
  localparam int unsigned RandChars = 110;
  localparam int unsigned PrintMax = 50;

  typedef struct {
    logic [7:0]  code;
    logic        last;
    int unsigned gap;
  } char_xfer_t;

  typedef struct {
    logic             accepted;
    cause_e           cause;
    logic [AddrW-1:0] address;
  } verdict_t;

  logic clk_i;
  logic rst_ni;

  matp_char_if    chr_if ();
  matp_verdict_if vrd_if ();

  mac_address_text_parser_unit u_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .chr_i (chr_if),
    .vrd_o (vrd_if)
  );

  char_xfer_t  char_q[$];
  verdict_t    verdict_q[$];
  logic [7:0]  text_buf[$];
  string       alphabet = "0123456789abcdefABCDEF-.:";

  logic [PosW-1:0]  text_pos;
  logic [AddrW-1:0] text_acc;
  logic             sep_bad;
  logic             digit_bad;

  char_xfer_t  pend;
  int unsigned gap_cnt;
  int unsigned stall_left;
  int unsigned idle_cycles;
  int unsigned fail_count;
  int unsigned chars_queued;
  int unsigned texts_queued;
  int unsigned chars_sent;
  int unsigned verdicts_seen;
  int unsigned cause_hits[5];

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    rst_ni = 1'b0;
    chr_if.valid = 1'b0;
    chr_if.char_code = 8'h00;
    chr_if.is_last = 1'b0;
    vrd_if.ready = 1'b0;
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
  end

  function automatic logic [4:0] digit_value(input logic [7:0] c);
    if (c >= "0" && c <= "9") begin
      return 5'(c - "0");
    end else if (c >= "a" && c <= "f") begin
      return 5'(c - "a" + 8'd10);
    end else if (c >= "A" && c <= "F") begin
      return 5'(c - "A" + 8'd10);
    end
    return 5'd16;
  endfunction

  task automatic report_mismatch(input string msg);
    fail_count++;
    if (fail_count <= PrintMax) begin
      $display("mismatch at %0t: %s", $time, msg);
    end
  endtask

  task automatic predict_char(input logic [7:0] c, input logic last);
    logic [4:0] v;
    verdict_t   vd;
    if (text_pos < TextLen) begin
      if (text_pos % 3 == 2) begin
        if (!(c == ChDash || c == ChDot || c == ChColon)) sep_bad = 1'b1;
      end else begin
        v = digit_value(c);
        if (v[4]) begin
          digit_bad = 1'b1;
          v = 5'd0;
        end
        text_acc = {text_acc[AddrW-5:0], v[3:0]};
      end
    end
    if (text_pos < PosSat) text_pos = text_pos + 1'b1;
    if (last) begin
      vd.address = text_acc;
      if (text_pos != TextLen) begin
        vd.cause = CAUSE_LEN;
      end else if (sep_bad) begin
        vd.cause = CAUSE_SEP;
      end else if (digit_bad) begin
        vd.cause = CAUSE_DIGIT;
      end else if (text_acc == '0 || text_acc == AddrOnes || (text_acc & McastBit) != '0) begin
        vd.cause = CAUSE_RSVD;
      end else begin
        vd.cause = CAUSE_OK;
      end
      vd.accepted = (vd.cause == CAUSE_OK);
      if (!vd.accepted) vd.address = '0;
      verdict_q.push_back(vd);
      cause_hits[int'(vd.cause)]++;
      text_pos = '0;
      text_acc = '0;
      sep_bad = 1'b0;
      digit_bad = 1'b0;
    end
  endtask

  task automatic check_verdict();
    verdict_t vd;
    if (verdict_q.size() == 0) begin
      report_mismatch($sformatf("verdict with no text pending, cause %0d", vrd_if.cause));
    end else begin
      vd = verdict_q.pop_front();
      if (vrd_if.accepted !== vd.accepted) begin
        report_mismatch($sformatf("accepted %b, want %b", vrd_if.accepted, vd.accepted));
      end
      if (vrd_if.cause !== vd.cause) begin
        report_mismatch($sformatf("cause %0d, want %0d", vrd_if.cause, vd.cause));
      end
      if (vrd_if.address !== vd.address) begin
        report_mismatch($sformatf("address %h, want %h", vrd_if.address, vd.address));
      end
    end
  endtask

  // character driver
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      chr_if.valid <= 1'b0;
      gap_cnt = 0;
      text_pos = '0;
      text_acc = '0;
      sep_bad = 1'b0;
      digit_bad = 1'b0;
    end else begin
      if (chr_if.valid && chr_if.ready) begin
        predict_char(chr_if.char_code, chr_if.is_last);
        chars_sent++;
      end
      if (!chr_if.valid || chr_if.ready) begin
        if (char_q.size() != 0 && gap_cnt >= char_q[0].gap) begin
          pend = char_q.pop_front();
          chr_if.valid <= 1'b1;
          chr_if.char_code <= pend.code;
          chr_if.is_last <= pend.last;
          gap_cnt = 0;
        end else begin
          chr_if.valid <= 1'b0;
          if (char_q.size() != 0) gap_cnt++;
        end
      end
    end
  end

  // verdict monitor
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      vrd_if.ready <= 1'b0;
      stall_left = 0;
    end else if (vrd_if.valid && vrd_if.ready) begin
      check_verdict();
      verdicts_seen++;
      stall_left = ((verdicts_seen / 16) % 3 == 0) ? 0 : $urandom_range(0, GapMax);
      vrd_if.ready <= (stall_left == 0);
    end else if (!vrd_if.ready) begin
      if (stall_left > 1) begin
        stall_left--;
      end else begin
        stall_left = 0;
        vrd_if.ready <= 1'b1;
      end
    end
  end

  // watchdog on transfers
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((chr_if.valid && chr_if.ready) || (vrd_if.valid && vrd_if.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IdleLimit) begin
        $display("timeout: no transfer for %0d cycles", IdleLimit);
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    if (n < 4'd10) return 8'("0" + n);
    return 8'(($urandom_range(0, 1) ? "A" : "a") + n - 8'd10);
  endfunction

  function automatic logic [7:0] random_sep();
    case ($urandom_range(0, 2))
      0: return ChDash;
      1: return ChDot;
      default: return ChColon;
    endcase
  endfunction

  function automatic logic [AddrW-1:0] random_address();
    logic [63:0]      r;
    logic [AddrW-1:0] a;
    r = {$urandom, $urandom};
    a = r[AddrW-1:0];
    case ($urandom_range(0, 11))
      0: a = '0;
      1: a = AddrOnes;
      2: a = a | McastBit;
      default: if ($urandom_range(0, 3) != 0) a = a & ~McastBit;
    endcase
    return a;
  endfunction

  task automatic build_text(input logic [AddrW-1:0] a);
    logic [7:0] b;
    text_buf.delete();
    for (int i = 0; i < 6; i++) begin
      b = a[AddrW-1-8*i -: 8];
      text_buf.push_back(hex_char(b[7:4]));
      text_buf.push_back(hex_char(b[3:0]));
      if (i < 5) text_buf.push_back(random_sep());
    end
  endtask

  task automatic send_text();
    char_xfer_t x;
    logic       calm;
    calm = ((texts_queued / 8) % 3 == 1);
    for (int i = 0; i < text_buf.size(); i++) begin
      x.code = text_buf[i];
      x.last = (i == text_buf.size() - 1);
      x.gap = calm ? 0 : $urandom_range(0, GapMax);
      char_q.push_back(x);
      chars_queued++;
    end
    texts_queued++;
  endtask

  task automatic send_str(input string s);
    text_buf.delete();
    for (int i = 0; i < s.len(); i++) text_buf.push_back(s[i]);
    send_text();
  endtask

  initial begin
    int unsigned rand_start;
    int unsigned n;
    send_str("02:1a:3B:4c:5D:6e");
    send_str("0A-BC-DE-F0-12-34");
    send_str("12.34.56.78.9a.bc");
    send_str("fE:dC:bA:98:76:54");
    send_str("00:00:00:00:00:00");
    send_str("ff:FF:ff:FF:ff:FF");
    send_str("01:23:45:67:89:ab");
    send_str("02:00:00:00:00:0");
    send_str("02:00:00:00:00:001");
    send_str("02:00:00:00:00:00:11:22");
    send_str("7");
    send_str("02;00:00:00:00:01");
    send_str("0g:00:00:00:00:01");
    send_str("02:0/:@0:`0:G0:01");
    send_str("0g/00:00:00:00:01");
    send_str("0g/00:00");
    // lowest and highest codes at digit positions, lowest code at a separator position
    build_text(48'h02_00_00_00_00_01);
    text_buf[0] = 8'hFF;
    text_buf[2] = 8'h00;
    send_text();
    build_text(48'h02_00_00_00_00_01);
    text_buf[4] = 8'h00;
    text_buf[16] = 8'hFF;
    send_text();

    rand_start = chars_queued;
    while (chars_queued < rand_start + RandChars) begin
      case ($urandom_range(0, 9))
        6: begin
          build_text(random_address());
          text_buf[$urandom_range(0, 16)] = 8'($urandom_range(0, 255));
        end
        7: begin
          build_text(random_address());
          n = $urandom_range(1, 3);
          if ($urandom_range(0, 1)) begin
            repeat (n) void'(text_buf.pop_back());
          end else begin
            repeat (n) text_buf.push_back(alphabet[$urandom_range(0, alphabet.len() - 1)]);
          end
        end
        8, 9: begin
          text_buf.delete();
          n = $urandom_range(1, 22);
          repeat (n) begin
            if ($urandom_range(0, 1)) begin
              text_buf.push_back(8'($urandom_range(0, 255)));
            end else begin
              text_buf.push_back(alphabet[$urandom_range(0, alphabet.len() - 1)]);
            end
          end
        end
        default: build_text(random_address());
      endcase
      send_text();
    end

    do @(posedge clk_i);
    while (!rst_ni || char_q.size() != 0 || chr_if.valid || verdict_q.size() != 0);
    repeat (SettleCycles) @(posedge clk_i);
    if (verdict_q.size() != 0) report_mismatch("verdicts still pending at the end");

    $display("run covered %0d characters in %0d texts, %0d verdicts checked",
             chars_sent, texts_queued, verdicts_seen);
    $display("verdicts by cause: ok %0d, length %0d, separator %0d, digit %0d, reserved %0d",
             cause_hits[0], cause_hits[1], cause_hits[2], cause_hits[3], cause_hits[4]);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

FILE: mac_address_text_parser_unit.f
+incdir+sv
sv/matp_pkg.sv
sv/matp_if.sv
sv/mac_address_text_parser_unit.sv
tb/tb_top.sv
